@@ src/prpv_pkg.sv @@
// prpv_pkg: shared types and constants of the press/release peak-valley detector
// holds field widths, register index codes, request codes and the result record
// no dependencies

package prpv_pkg;

	// fixed port widths
	localparam int SAMPLE_W  = 12;
	localparam int THR_W     = 12;
	localparam int CFG_IDX_W = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_ON  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_OFF = 1'b1;

	// request codes
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_CLEAR  = 1'b1;

	// one result transaction
	typedef struct packed {
		logic released;
		logic state_changed;
		logic alarm_fire;
		logic peak_rising;
	} result_t;

endpackage

@@ src/press_release_peak_valley_detector.sv @@
// press_release_peak_valley_detector: per-channel peak/valley tracking with hysteresis
// and a shared alarm latch; one input register stage, one result register
// depends on prpv_pkg

//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------------
//  in      | in_valid / in_stall   | req_type, channel, sample
//  out     | out_valid / out_stall | released, state_changed, alarm_fire,
//          |                       | peak_rising
//  cfg     | cfg_we                | cfg_index, cfg_wdata
//
//  a transaction passes the input register, then the state update and the result
//  register; one transaction per cycle is sustained while the output is not
//  stalled, set by the single read-modify-write of the channel state
//  reset clears all channel state, both thresholds and the alarm latch
//  in_stall rises only when the input register holds a transaction and the
//  result register is full and stalled

module press_release_peak_valley_detector
	import prpv_pkg::*;
#(
	parameter int SAMPLE_BITS  = 12,
	parameter int NUM_CHANNELS = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,

	// configuration
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [THR_W-1:0]     cfg_wdata,

	// input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 req_type,
	input  logic                 channel,
	input  logic [SAMPLE_W-1:0]  sample,

	// output channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 released,
	output logic                 state_changed,
	output logic                 alarm_fire,
	output logic                 peak_rising
);

	// index width into the channel state; at least one bit
	localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	// width for comparing a sample difference against a threshold
	localparam int CMP_W    = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

	// thresholds
	logic [THR_W-1:0] thr_on_q;
	logic [THR_W-1:0] thr_off_q;

	// per-channel state
	logic [NUM_CHANNELS-1:0] released_q;
	logic [SAMPLE_BITS-1:0]  peak_q   [NUM_CHANNELS];
	logic [SAMPLE_BITS-1:0]  valley_q [NUM_CHANNELS];
	logic                    alarm_q;

	// input register stage
	logic                valid_s1;
	logic                req_s1;
	logic                channel_s1;
	logic [SAMPLE_W-1:0] sample_s1;

	// result register
	logic    out_valid_q;
	result_t res_q;

	// pipeline control
	logic advance;
	logic in_accept;

	// update logic
	logic                   ch_ok;
	logic [CH_IDX_W-1:0]    idx;
	logic [SAMPLE_BITS-1:0] samp;
	logic                   cur_rel;
	logic [SAMPLE_BITS-1:0] cur_peak;
	logic [SAMPLE_BITS-1:0] cur_valley;
	logic [SAMPLE_BITS-1:0] drop;
	logic [SAMPLE_BITS-1:0] rise;
	logic                   nxt_rel;
	logic [SAMPLE_BITS-1:0] nxt_peak;
	logic [SAMPLE_BITS-1:0] nxt_valley;
	logic                   state_we;
	result_t                res_d;

	// the stage moves when the result register is empty or being drained
	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_on_q  <= '0;
			thr_off_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD_ON:  thr_on_q  <= cfg_wdata;
				REG_THRESHOLD_OFF: thr_off_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input register: valid is control, payload needs no reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || !valid_s1) begin
			valid_s1 <= in_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_s1     <= req_type;
			channel_s1 <= channel;
			sample_s1  <= sample;
		end
	end

	// channel state lookup; out-of-range channels are masked by ch_ok
	always_comb begin
		ch_ok      = 32'(channel_s1) < NUM_CHANNELS;
		idx        = CH_IDX_W'(channel_s1);
		samp       = SAMPLE_BITS'(sample_s1);
		cur_rel    = released_q[idx];
		cur_peak   = peak_q[idx];
		cur_valley = valley_q[idx];
		drop       = cur_peak - samp;
		rise       = samp - cur_valley;
	end

	// hysteresis step for one sample, or a clear request
	always_comb begin
		nxt_rel    = cur_rel;
		nxt_peak   = cur_peak;
		nxt_valley = cur_valley;
		state_we   = 1'b0;
		res_d      = '0;

		if (req_s1 == REQ_CLEAR) begin
			// clear only touches the alarm latch
			res_d.released = ch_ok && cur_rel;
		end else if (ch_ok) begin
			state_we = 1'b1;
			if (!cur_rel) begin
				if (samp >= cur_peak) begin
					nxt_peak          = samp;
					res_d.peak_rising = 1'b1;
				end else if (CMP_W'(drop) >= CMP_W'(thr_on_q)) begin
					nxt_valley          = samp;
					nxt_rel             = 1'b1;
					res_d.state_changed = 1'b1;
				end
			end else begin
				if (samp <= cur_valley) begin
					nxt_valley = samp;
				end else if (CMP_W'(rise) >= CMP_W'(thr_off_q)) begin
					nxt_peak            = samp;
					nxt_rel             = 1'b0;
					res_d.state_changed = 1'b1;
				end
			end
			res_d.released   = nxt_rel;
			// alarm fires only on the first release since the last clear
			res_d.alarm_fire = nxt_rel && res_d.state_changed && !alarm_q;
		end
	end

	// state write-back as the transaction enters the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			released_q <= '0;
			alarm_q    <= 1'b0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				peak_q[i]   <= '0;
				valley_q[i] <= '0;
			end
		end else if (advance && valid_s1) begin
			if (state_we) begin
				released_q[idx] <= nxt_rel;
				peak_q[idx]     <= nxt_peak;
				valley_q[idx]   <= nxt_valley;
			end
			if (req_s1 == REQ_CLEAR) begin
				alarm_q <= 1'b0;
			end else if (res_d.alarm_fire) begin
				alarm_q <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q <= res_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign released      = res_q.released;
	assign state_changed = res_q.state_changed;
	assign alarm_fire    = res_q.alarm_fire;
	assign peak_rising   = res_q.peak_rising;

endmodule
